// ===== hw/rtl/steer_pkg.sv =====
// shared types, constants and helper functions of the steering drive command unit
`default_nettype none
package steer_pkg;

   localparam logic [2:0] ACT_TARGET    = 3'd0;
   localparam logic [2:0] ACT_STEP      = 3'd1;
   localparam logic [2:0] ACT_ENCODER   = 3'd2;
   localparam logic [2:0] ACT_ENGAGE    = 3'd3;
   localparam logic [2:0] ACT_DISENGAGE = 3'd4;

   localparam logic [2:0] CSR_DRIVE_MODE     = 3'd0;
   localparam logic [2:0] CSR_INVERT_FLAGS   = 3'd1;
   localparam logic [2:0] CSR_SPEED_MAX      = 3'd2;
   localparam logic [2:0] CSR_SPEED_MIN      = 3'd3;
   localparam logic [2:0] CSR_GAIN           = 3'd4;
   localparam logic [2:0] CSR_STEPS_PER_TURN = 3'd5;
   localparam logic [2:0] CSR_ANGLE_PER_TURN = 3'd6;
   localparam logic [2:0] CSR_DRIFT_GAIN     = 3'd7;

   localparam logic [15:0] ENCODER_COUNTS_PER_TURN = 16'd4000;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [7:0]  MB_SLAVE  = 8'h01;
   localparam logic [7:0]  MB_FUNC   = 8'h06;
   localparam logic [7:0]  MB_REG_HI = 8'h00;
   localparam logic [7:0]  MB_REG_LO = 8'h6A;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_beat_type;

   typedef struct packed {
      logic signed [8:0] drive_value;
      logic              is_frame_byte;
      logic [7:0]        frame_byte;
      logic              last;
   } rsp_beat_type;

   typedef struct packed {
      logic        drive_mode;
      logic [1:0]  invert_flags;
      logic [7:0]  speed_max;
      logic [7:0]  speed_min;
      logic [15:0] gain;
      logic [15:0] steps_per_turn;
      logic [30:0] angle_per_turn;
      logic [15:0] drift_gain;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        neg;
      logic [47:0] mag;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < 50'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == SAT_MIN) begin
         r = SAT_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_sel(input logic [2:0] idx, input logic signed [8:0] res,
                                            input logic [15:0] crc);
      logic [15:0] r16;
      logic [7:0]  b;
      r16 = {{7{res[8]}}, res};
      case (idx)
         3'd0: b = MB_SLAVE;
         3'd1: b = MB_FUNC;
         3'd2: b = MB_REG_HI;
         3'd3: b = MB_REG_LO;
         3'd4: b = r16[15:8];
         3'd5: b = r16[7:0];
         3'd6: b = crc[7:0];
         3'd7: b = crc[15:8];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/steer_front.sv =====
// front end: takes request beats, drops unknown actions, forms dividend magnitude and sign
`default_nettype none
module steer_front (
   input  wire                      req_valid,
   input  steer_pkg::req_beat_type  req_beat,
   output logic                     req_stall,
   input  wire                      queue_full,
   output logic                     push,
   output steer_pkg::cmd_type       cmd
);
   import steer_pkg::*;

   logic        known;
   logic [15:0] rd;
   logic [15:0] rd_mag;
   logic [31:0] v_mag;

   assign known     = (req_beat.action <= ACT_DISENGAGE);
   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full & known;

   always_comb begin
      rd     = req_beat.value[15:0];
      rd_mag = rd[15] ? (16'd0 - rd) : rd;
      v_mag  = req_beat.value[31] ? (32'd0 - req_beat.value) : req_beat.value;
      cmd.op = req_beat.action;
      if (req_beat.action == ACT_ENCODER) begin
         cmd.neg = rd[15];
         cmd.mag = {16'd0, rd_mag, 16'd0};
      end else begin
         cmd.neg = req_beat.value[31];
         cmd.mag = {v_mag, 16'd0};
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/steer_queue.sv =====
// command queue between front end and back end
`default_nettype none
module steer_queue #(
   parameter int DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  steer_pkg::cmd_type  push_cmd,
   output logic                full,
   input  wire                 pop,
   output logic                empty,
   output steer_pkg::cmd_type  pop_cmd
);
   import steer_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem [DEPTH];
   logic [AW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/steer_back.sv =====
// back end: serial divider, position state, drive computation, crc and result beats
`default_nettype none
module steer_back (
   input  wire                      clock,
   input  wire                      reset,
   input  steer_pkg::cfg_type       cfg,
   input  wire                      queue_empty,
   input  steer_pkg::cmd_type       cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output steer_pkg::rsp_beat_type  rsp_beat
);
   import steer_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIV    = 4'd1;
   localparam logic [3:0] ST_DIVEND = 4'd2;
   localparam logic [3:0] ST_TMUL   = 4'd3;
   localparam logic [3:0] ST_TDRIFT = 4'd4;
   localparam logic [3:0] ST_TTOT   = 4'd5;
   localparam logic [3:0] ST_EPOS   = 4'd6;
   localparam logic [3:0] ST_EMUL   = 4'd7;
   localparam logic [3:0] ST_M0LO   = 4'd8;
   localparam logic [3:0] ST_M0HI   = 4'd9;
   localparam logic [3:0] ST_M1     = 4'd10;
   localparam logic [3:0] ST_CRC    = 4'd11;
   localparam logic [3:0] ST_EMIT   = 4'd12;

   logic [3:0]         state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic               neg_ff, neg_in;
   logic [31:0]        rem_ff, rem_in;
   logic [47:0]        quo_ff, quo_in;
   logic [30:0]        div_ff, div_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [31:0] turns_ff, turns_in;
   logic [31:0]        inc_ff, inc_in;
   logic signed [31:0] drift_sum_ff, drift_sum_in;
   logic signed [31:0] target_total_ff, target_total_in;
   logic signed [31:0] measured_ff, measured_in;
   logic signed [31:0] last_reading_ff, last_reading_in;
   logic [15:0]        turn_count_ff, turn_count_in;
   logic               engaged_ff, engaged_in;
   logic [47:0]        m_ff, m_in;
   logic               pneg_ff, pneg_in;
   logic               frame_ff, frame_in;
   logic [15:0]        lo_ff, lo_in;
   logic signed [8:0]  res_ff, res_in;
   logic [15:0]        crc_ff, crc_in;
   logic [2:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_beat_ff, rsp_beat_in;

   logic               slot_free;
   logic [32:0]        trial;
   logic signed [31:0] turns_sat;
   logic signed [32:0] diff;
   logic signed [32:0] err;
   logic signed [49:0] prod;
   logic [31:0]        tmag;
   logic [47:0]        tprod;
   logic [15:0]        st;
   logic [39:0]        lo_prod;
   logic [40:0]        q_sum;
   logic [20:0]        q_cap;
   logic [20:0]        q_eng;
   logic [7:0]         mag;
   logic [7:0]         beat_byte;
   logic               beat_last;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;
   assign st        = (cfg.steps_per_turn == 16'd0) ? 16'd1 : cfg.steps_per_turn;
   assign pop       = (state_ff == ST_IDLE) & ~queue_empty;

   always_comb begin
      trial = {1'b0, rem_ff[30:0], quo_ff[47]} - {2'b00, div_ff};
      if (!neg_ff) begin
         turns_sat = (|quo_ff[47:31]) ? SAT_MAX : quo_ff[31:0];
      end else if ((|quo_ff[47:32]) || (quo_ff[31] && (|quo_ff[30:0]))) begin
         turns_sat = SAT_MIN;
      end else begin
         turns_sat = 32'd0 - quo_ff[31:0];
      end
      diff    = 33'(last_reading_ff) - 33'(turns_sat);
      err     = 33'(target_total_ff) - 33'(measured_ff);
      prod    = 50'(err) * $signed({34'd0, cfg.gain});
      tmag    = turns_ff[31] ? (32'd0 - turns_ff) : turns_ff;
      tprod   = 48'(tmag) * 48'(cfg.drift_gain);
      lo_prod = 40'(m_ff[23:0]) * 40'(st);
      q_sum   = 41'(40'(m_ff[47:24]) * 40'(st)) + 41'(lo_ff);
      beat_byte = frame_ff ? frame_sel(idx_ff, res_ff, crc_ff) : 8'd0;
      beat_last = ~frame_ff | (idx_ff == 3'd7);
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      neg_in          = neg_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      div_in          = div_ff;
      cnt_in          = cnt_ff;
      turns_in        = turns_ff;
      inc_in          = inc_ff;
      drift_sum_in    = drift_sum_ff;
      target_total_in = target_total_ff;
      measured_in     = measured_ff;
      last_reading_in = last_reading_ff;
      turn_count_in   = turn_count_ff;
      engaged_in      = engaged_ff;
      m_in            = m_ff;
      pneg_in         = pneg_ff;
      frame_in        = frame_ff;
      lo_in           = lo_ff;
      res_in          = res_ff;
      crc_in          = crc_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_beat_in     = rsp_beat_ff;
      q_cap           = 21'd0;
      q_eng           = 21'd0;
      mag             = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               op_in  = cmd.op;
               neg_in = cmd.neg;
               rem_in = 32'd0;
               quo_in = cmd.mag;
               cnt_in = 6'd0;
               case (cmd.op)
                  ACT_ENGAGE: begin
                     engaged_in = 1'b1;
                  end
                  ACT_DISENGAGE: begin
                     engaged_in = 1'b0;
                  end
                  ACT_TARGET: begin
                     if (engaged_ff) begin
                        div_in   = (cfg.angle_per_turn == 31'd0) ? 31'd1 : cfg.angle_per_turn;
                        state_in = ST_DIV;
                     end
                  end
                  ACT_STEP: begin
                     div_in   = {15'd0, st};
                     state_in = ST_DIV;
                  end
                  ACT_ENCODER: begin
                     div_in   = {15'd0, ENCODER_COUNTS_PER_TURN};
                     state_in = ST_DIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[47]};
            end
            quo_in = {quo_ff[46:0], ~trial[32]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            case (op_ff)
               ACT_TARGET: begin
                  turns_in = turns_sat;
                  state_in = ST_TMUL;
               end
               ACT_STEP: begin
                  measured_in = cfg.invert_flags[1] ? neg32(turns_sat) : turns_sat;
                  state_in    = ST_EMUL;
               end
               default: begin
                  if (diff > 33'sd32768) begin
                     turn_count_in = turn_count_ff + 16'd1;
                  end else if (diff < -33'sd32768) begin
                     turn_count_in = turn_count_ff - 16'd1;
                  end
                  last_reading_in = turns_sat;
                  state_in        = ST_EPOS;
               end
            endcase
         end
         ST_TMUL: begin
            inc_in   = tprod[47:16];
            state_in = ST_TDRIFT;
         end
         ST_TDRIFT: begin
            if (turns_ff[31]) begin
               drift_sum_in = sat32(50'(drift_sum_ff) - 50'($signed({1'b0, inc_ff})));
            end else begin
               drift_sum_in = sat32(50'(drift_sum_ff) + 50'($signed({1'b0, inc_ff})));
            end
            state_in = ST_TTOT;
         end
         ST_TTOT: begin
            target_total_in = sat32(50'(drift_sum_ff) + 50'(turns_ff));
            state_in        = ST_IDLE;
         end
         ST_EPOS: begin
            measured_in = sat32(50'($signed({turn_count_ff, 16'd0})) + 50'(last_reading_ff));
            if (cfg.invert_flags[1]) begin
               measured_in = neg32(measured_in);
            end
            state_in = ST_EMUL;
         end
         ST_EMUL: begin
            pneg_in  = prod[49];
            m_in     = prod[49] ? 48'(-prod) : prod[47:0];
            frame_in = cfg.drive_mode;
            state_in = cfg.drive_mode ? ST_M1 : ST_M0LO;
         end
         ST_M0LO: begin
            lo_in    = lo_prod[39:24];
            state_in = ST_M0HI;
         end
         ST_M0HI: begin
            if (m_ff[47] || (q_sum > 41'h100000)) begin
               q_cap = 21'h100000;
            end else begin
               q_cap = q_sum[20:0];
            end
            q_eng = engaged_ff ? q_cap : 21'd0;
            mag   = (q_eng > 21'(cfg.speed_max)) ? cfg.speed_max : q_eng[7:0];
            if ((mag != 8'd0) && (mag < cfg.speed_min)) begin
               mag = 8'd0;
            end
            res_in   = (pneg_ff ^ cfg.invert_flags[0]) ? -$signed({1'b0, mag})
                                                       : $signed({1'b0, mag});
            idx_in   = 3'd0;
            state_in = ST_EMIT;
         end
         ST_M1: begin
            mag      = (m_ff[47:24] > 24'(cfg.speed_max)) ? cfg.speed_max : m_ff[31:24];
            res_in   = pneg_ff ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
            crc_in   = CRC_INIT;
            idx_in   = 3'd0;
            state_in = ST_CRC;
         end
         ST_CRC: begin
            crc_in = crc_update(crc_ff, frame_sel(idx_ff, res_ff, crc_ff));
            if (idx_ff == 3'd5) begin
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_beat_in.drive_value   = res_ff;
               rsp_beat_in.is_frame_byte = frame_ff;
               rsp_beat_in.frame_byte    = beat_byte;
               rsp_beat_in.last          = beat_last;
               idx_in                    = idx_ff + 3'd1;
               if (beat_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      turns_ff    <= turns_in;
      inc_ff      <= inc_in;
      m_ff        <= m_in;
      pneg_ff     <= pneg_in;
      frame_ff    <= frame_in;
      lo_ff       <= lo_in;
      res_ff      <= res_in;
      idx_ff      <= idx_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         drift_sum_ff    <= '0;
         target_total_ff <= '0;
         measured_ff     <= '0;
         last_reading_ff <= '0;
         turn_count_ff   <= '0;
         engaged_ff      <= 1'b0;
         crc_ff          <= CRC_INIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         drift_sum_ff    <= drift_sum_in;
         target_total_ff <= target_total_in;
         measured_ff     <= measured_in;
         last_reading_ff <= last_reading_in;
         turn_count_ff   <= turn_count_in;
         engaged_ff      <= engaged_in;
         crc_ff          <= crc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/steering_drive_command_unit.sv =====
// A 48-step serial divider sets most of the time from a request beat to its first response beat.
// A measurement gives one response beat in mode 0 and a frame of 8 beats in mode 1.
// A command queue of QUEUE_DEPTH entries (two by default) lets request beats be taken while the back end works.
// Reset (synchronous, active high) clears position state, engage flag and queue and loads the default config.
`default_nettype none
module steering_drive_command_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  steer_pkg::req_beat_type  req_beat,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output steer_pkg::rsp_beat_type  rsp_beat,
   input  wire                      csr_write,
   input  wire [2:0]                csr_index,
   input  wire [30:0]               csr_wdata
);
   import steer_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, pop_cmd;
   logic    push, pop, queue_full, queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DRIVE_MODE:     cfg_in.drive_mode     = csr_wdata[0];
            CSR_INVERT_FLAGS:   cfg_in.invert_flags   = csr_wdata[1:0];
            CSR_SPEED_MAX:      cfg_in.speed_max      = csr_wdata[7:0];
            CSR_SPEED_MIN:      cfg_in.speed_min      = csr_wdata[7:0];
            CSR_GAIN:           cfg_in.gain           = csr_wdata[15:0];
            CSR_STEPS_PER_TURN: cfg_in.steps_per_turn = csr_wdata[15:0];
            CSR_ANGLE_PER_TURN: cfg_in.angle_per_turn = csr_wdata[30:0];
            CSR_DRIFT_GAIN:     cfg_in.drift_gain     = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_mode     <= 1'b0;
         cfg_ff.invert_flags   <= 2'd0;
         cfg_ff.speed_max      <= 8'd255;
         cfg_ff.speed_min      <= 8'd0;
         cfg_ff.gain           <= 16'd256;
         cfg_ff.steps_per_turn <= 16'd1000;
         cfg_ff.angle_per_turn <= 31'd205887;
         cfg_ff.drift_gain     <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   steer_front u_front (
      .req_valid  (req_valid),
      .req_beat   (req_beat),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   steer_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_cmd  (pop_cmd)
   );

   steer_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .cmd         (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat)
   );

endmodule
`default_nettype wire

// ===== bench/tb_steering_drive_command_unit.sv =====
// self-checking testbench of the steering drive command unit: directed table, then random phases
`default_nettype none
module tb_steering_drive_command_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import steer_pkg::*;

   localparam logic [2:0] ACT_RESERVED = 3'd5;
   localparam logic [2:0] ACT_UNUSED_A = 3'd6;
   localparam logic [2:0] ACT_UNUSED_B = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 21;

   typedef struct {
      logic [2:0]        action;
      logic [31:0]       value;
      bit                typed;
      logic signed [8:0] drive_value;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_beat_type req_beat;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_beat_type rsp_beat;
   logic         csr_write;
   logic [2:0]   csr_index;
   logic [30:0]  csr_wdata;

   steering_drive_command_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow configuration and position state
   cfg_type     shadow_cfg;
   longint      drift_acc, target_sum, position_now, prev_reading;
   logic [15:0] turns_seen;
   bit          is_engaged;

   rsp_beat_type drive_expect[$];
   int  mismatches = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;
   int  hold_cnt = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic [15:0] modbus_crc(input logic [7:0] bytes[6]);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int k = 0; k < 6; k++) begin
         c ^= {8'd0, bytes[k]};
         for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         end
      end
      return c;
   endfunction

   function automatic longint mag_shift(input longint a, input longint b, input int sh);
      longint m;
      m = ((a < 0) ? -a : a) * b >>> sh;
      return (a < 0) ? -m : m;
   endfunction

   task automatic push_drive();
      longint err, p, m, q, res, lim, mn, st;
      logic [7:0]  fb[8];
      logic [7:0]  head[6];
      logic [15:0] crc;
      rsp_beat_type r;
      err = target_sum - position_now;
      p = err * longint'(shadow_cfg.gain);
      m = (p < 0) ? -p : p;
      lim = longint'(shadow_cfg.speed_max);
      if (!shadow_cfg.drive_mode) begin
         st = (shadow_cfg.steps_per_turn == 0) ? 1 : longint'(shadow_cfg.steps_per_turn);
         mn = longint'(shadow_cfg.speed_min);
         if (m >= (64'sd1 << 47)) q = 64'sd1 << 20;
         else q = (m * st) >>> 24;
         if (q > (64'sd1 << 20)) q = 64'sd1 << 20;
         res = (p < 0) ? -q : q;
         if (shadow_cfg.invert_flags[0]) res = -res;
         if (!is_engaged) res = 0;
         if (res > lim) res = lim;
         if (res < -lim) res = -lim;
         if (res > 0 && res < mn) res = 0;
         if (res < 0 && res > -mn) res = 0;
         r.drive_value = res[8:0];
         r.is_frame_byte = 1'b0;
         r.frame_byte = 8'd0;
         r.last = 1'b1;
         drive_expect = {drive_expect, r};
      end else begin
         q = m >>> 24;
         res = (p < 0) ? q : -q;
         if (res > lim) res = lim;
         if (res < -lim) res = -lim;
         fb[0] = MB_SLAVE; fb[1] = MB_FUNC; fb[2] = MB_REG_HI; fb[3] = MB_REG_LO;
         fb[4] = res[15:8]; fb[5] = res[7:0];
         for (int k = 0; k < 6; k++) head[k] = fb[k];
         crc = modbus_crc(head);
         fb[6] = crc[7:0]; fb[7] = crc[15:8];
         for (int k = 0; k < 8; k++) begin
            r.drive_value = res[8:0];
            r.is_frame_byte = 1'b1;
            r.frame_byte = fb[k];
            r.last = (k == 7);
            drive_expect = {drive_expect, r};
         end
      end
   endtask

   task automatic apply_measured(input longint turns);
      position_now = shadow_cfg.invert_flags[1] ? clip32(-turns) : turns;
   endtask

   task automatic predict_steering(input logic [2:0] act, input logic [31:0] raw);
      longint v, ap, st, turns, val, diff, tc, rd;
      v = longint'(signed'(raw));
      case (act)
         ACT_TARGET: begin
            ap = (shadow_cfg.angle_per_turn == 0) ? 1 : longint'(shadow_cfg.angle_per_turn);
            if (is_engaged) begin
               turns = clip32((v * 65536) / ap);
               drift_acc = clip32(drift_acc + mag_shift(turns, shadow_cfg.drift_gain, 16));
               target_sum = clip32(drift_acc + turns);
            end
         end
         ACT_STEP: begin
            st = (shadow_cfg.steps_per_turn == 0) ? 1 : longint'(shadow_cfg.steps_per_turn);
            apply_measured(clip32((v * 65536) / st));
            push_drive();
         end
         ACT_ENCODER: begin
            rd = longint'(signed'(raw[15:0]));
            val = (rd * 65536) / longint'(ENCODER_COUNTS_PER_TURN);
            diff = prev_reading - val;
            if (diff > 32768) turns_seen = turns_seen + 16'd1;
            if (diff < -32768) turns_seen = turns_seen - 16'd1;
            prev_reading = val;
            tc = longint'(signed'(turns_seen));
            apply_measured(clip32(tc * 65536 + val));
            push_drive();
         end
         ACT_ENGAGE: is_engaged = 1;
         ACT_DISENGAGE: is_engaged = 0;
         default: ;
      endcase
   endtask

   task automatic send_beat(input logic [2:0] act, input logic [31:0] raw, input bit typed,
                            input logic signed [8:0] typed_dv);
      int gap;
      rsp_beat_type r;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat.action <= act;
      req_beat.value <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      predict_steering(act, raw);
      if (typed) begin
         r.drive_value = typed_dv;
         r.is_frame_byte = 1'b0;
         r.frame_byte = 8'd0;
         r.last = 1'b1;
         drive_expect[$] = r;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (drive_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DRIVE_MODE:     shadow_cfg.drive_mode = data[0];
         CSR_INVERT_FLAGS:   shadow_cfg.invert_flags = data[1:0];
         CSR_SPEED_MAX:      shadow_cfg.speed_max = data[7:0];
         CSR_SPEED_MIN:      shadow_cfg.speed_min = data[7:0];
         CSR_GAIN:           shadow_cfg.gain = data[15:0];
         CSR_STEPS_PER_TURN: shadow_cfg.steps_per_turn = data[15:0];
         CSR_ANGLE_PER_TURN: shadow_cfg.angle_per_turn = data[30:0];
         CSR_DRIFT_GAIN:     shadow_cfg.drift_gain = data[15:0];
         default: ;
      endcase
   endtask

   // response checking, receiver stall and watchdog
   always @(posedge clock) begin
      rsp_beat_type want;
      bit moved;
      if (reset) begin
         rsp_stall <= 1'b0;
         idle_cycles <= 0;
      end else begin
         moved = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (drive_expect.size() == 0) begin
               $error("unexpected response beat %p", rsp_beat);
               mismatches++;
            end else begin
               want = drive_expect.pop_front();
               if (rsp_beat.drive_value !== want.drive_value) begin
                  $error("drive_value exp %0d got %0d", want.drive_value, rsp_beat.drive_value);
                  mismatches++;
               end
               if (rsp_beat.is_frame_byte !== want.is_frame_byte) begin
                  $error("is_frame_byte exp %0d got %0d", want.is_frame_byte,
                         rsp_beat.is_frame_byte);
                  mismatches++;
               end
               if (rsp_beat.frame_byte !== want.frame_byte) begin
                  $error("frame_byte exp %h got %h", want.frame_byte, rsp_beat.frame_byte);
                  mismatches++;
               end
               if (rsp_beat.last !== want.last) begin
                  $error("last exp %0d got %0d", want.last, rsp_beat.last);
                  mismatches++;
               end
            end
            hold_cnt = quiet ? 0 : $urandom_range(0, 16);
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   stim_row_type table_rows[] = '{
      '{ACT_STEP,      32'd0,          1, 9'sd0},
      '{ACT_ENCODER,   32'h00007FFF,   1, 9'sd0},
      '{ACT_ENGAGE,    32'd0,          0, 9'sd0},
      '{ACT_STEP,      32'd1000,       1, -9'sd255},
      '{ACT_STEP,      -32'sd1000,     1, 9'sd255},
      '{ACT_STEP,      32'h7FFFFFFF,   1, -9'sd255},
      '{ACT_STEP,      32'h80000000,   1, 9'sd255},
      '{ACT_TARGET,    32'h7FFFFFFF,   0, 9'sd0},
      '{ACT_ENCODER,   32'h00007FFF,   0, 9'sd0},
      '{ACT_ENCODER,   32'hFFFF8000,   0, 9'sd0},
      '{ACT_TARGET,    32'h80000000,   0, 9'sd0},
      '{ACT_ENCODER,   32'h12340000,   0, 9'sd0},
      '{ACT_ENCODER,   32'h00000FA0,   0, 9'sd0},
      '{ACT_ENCODER,   32'hFFFFF060,   0, 9'sd0},
      '{ACT_TARGET,    32'd65536,      0, 9'sd0},
      '{ACT_STEP,      32'd1,          0, 9'sd0},
      '{ACT_RESERVED,  32'hFFFFFFFF,   0, 9'sd0},
      '{ACT_UNUSED_A,  32'd1,          0, 9'sd0},
      '{ACT_UNUSED_B,  32'd0,          0, 9'sd0},
      '{ACT_DISENGAGE, 32'd0,          0, 9'sd0},
      '{ACT_TARGET,    32'd1000000,    0, 9'sd0},
      '{ACT_STEP,      32'd500,        1, 9'sd0}
   };

   initial begin
      logic [2:0]  act;
      logic [31:0] val;
      int          pick;
      int          enc_walk;
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      csr_write = 1'b0;
      csr_index = CSR_DRIVE_MODE;
      csr_wdata = '0;
      shadow_cfg = '{drive_mode: 1'b0, invert_flags: 2'd0, speed_max: 8'd255, speed_min: 8'd0,
                     gain: 16'd256, steps_per_turn: 16'd1000, angle_per_turn: 31'd205887,
                     drift_gain: 16'd0};
      drift_acc = 0; target_sum = 0; position_now = 0; prev_reading = 0;
      turns_seen = 0; is_engaged = 0;
      enc_walk = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send_beat(table_rows[i].action, table_rows[i].value, table_rows[i].typed,
                   table_rows[i].drive_value);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         quiet = (ph == 2);
         write_reg(CSR_DRIVE_MODE, 31'(ph % 2));
         write_reg(CSR_INVERT_FLAGS, 31'(ph % 4));
         write_reg(CSR_SPEED_MAX, (ph == 0) ? 31'd0 : (ph == 1) ? 31'd255
                                                     : 31'($urandom_range(0, 255)));
         write_reg(CSR_SPEED_MIN, (ph == 3) ? 31'd255 : (ph == 4) ? 31'd0
                                                     : 31'($urandom_range(0, 40)));
         write_reg(CSR_GAIN, (ph == 1) ? 31'd65535 : (ph == 5) ? 31'd0
                                                   : 31'($urandom_range(0, 65535)));
         write_reg(CSR_STEPS_PER_TURN, (ph == 3) ? 31'd0 : (ph == 4) ? 31'd65535
                                                 : (ph == 5) ? 31'd1
                                                 : 31'($urandom_range(1, 4000)));
         write_reg(CSR_ANGLE_PER_TURN, (ph == 2) ? 31'd1 : (ph == 4) ? 31'h7FFFFFFF
                                                 : 31'($urandom_range(1000, 400000)));
         write_reg(CSR_DRIFT_GAIN, (ph == 2) ? 31'd65535 : (ph == 0) ? 31'd0
                                             : 31'($urandom_range(0, 65535)));
         csr_write <= 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            val = $urandom;
            if (pick < 10) begin
               act = ACT_ENGAGE;
            end else if (pick < 15) begin
               act = ACT_DISENGAGE;
            end else if (pick < 40) begin
               act = ACT_TARGET;
               if ($urandom_range(0, 2) != 0) val = 32'($signed($urandom_range(0, 400000)) - 200000);
            end else if (pick < 65) begin
               act = ACT_STEP;
               if ($urandom_range(0, 2) != 0) val = 32'($signed($urandom_range(0, 8000)) - 4000);
            end else if (pick < 95) begin
               act = ACT_ENCODER;
               if ($urandom_range(0, 3) != 0) begin
                  enc_walk = enc_walk + $signed($urandom_range(0, 3000)) - 1500;
                  if (enc_walk > 32767) enc_walk -= 65536;
                  if (enc_walk < -32768) enc_walk += 65536;
                  val = {16'($urandom_range(0, 65535)), 16'(enc_walk)};
               end
            end else begin
               act = 3'($urandom_range(ACT_RESERVED, ACT_UNUSED_B));
            end
            send_beat(act, val, 0, 9'sd0);
         end
         drain();
      end

      $display("sent %0d request beats over %0d settings, checked %0d response beats",
               beats_sent, PHASES + 1, beats_checked);
      $display("both drive modes, inversion, clamps, deadband and encoder turn wrap exercised");
      if (mismatches == 0 && drive_expect.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
